// ===== rtl/stack_watch_escalation_table_defines.svh =====
// ----------------------------------------------------------------------------
// stack_watch_escalation_table assertion macros
// Shared concurrent assertion forms for the checker.
// ----------------------------------------------------------------------------
`ifndef STACK_WATCH_ESCALATION_TABLE_DEFINES_SVH
`define STACK_WATCH_ESCALATION_TABLE_DEFINES_SVH

// same-cycle implication, disabled in reset
`define SWET_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled in reset
`define SWET_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/swet_pkg.sv =====
// ----------------------------------------------------------------------------
// swet_pkg
// Types and constants of the stack watch escalation table.
// ----------------------------------------------------------------------------
`default_nettype none

package swet_pkg;

  localparam int WATCH_ENTRIES_DEF = 8;
  localparam int APB_AW            = 3;
  localparam int APB_DW            = 32;

  localparam logic [15:0] THRESHOLD_RST = 16'd256;
  localparam logic [3:0]  LIMIT_RST     = 4'd5;
  localparam logic [3:0]  STREAK_MAX    = 4'd15;

  localparam logic REG_THRESHOLD = 1'b0;
  localparam logic REG_LIMIT     = 1'b1;

  localparam logic CMD_REPORT = 1'b0;
  localparam logic CMD_END    = 1'b1;

  typedef struct packed {
    logic        command;
    logic [15:0] task_id;
    logic [15:0] stack_free;
  } in_t;

  typedef struct packed {
    logic       low_stack;
    logic       alert;
    logic       restart_request;
    logic       table_full;
    logic [3:0] streak;
    logic [3:0] entries_in_use;
  } out_t;

  typedef struct packed {
    logic [15:0] threshold;
    logic [3:0]  limit;
  } cfg_t;

  typedef struct packed {
    logic [15:0] task_id;
    logic [3:0]  streak;
    logic        alerted;
    logic        seen;
  } entry_t;

endpackage

`default_nettype wire

// ===== rtl/stack_watch_escalation_table.sv =====
// ----------------------------------------------------------------------------
// stack_watch_escalation_table
// Low-stack escalation tracker over a small watch table of task ids.
// ----------------------------------------------------------------------------
// Usage:
//   Request channel: drive req_i and raise start; the request is taken at a
//   clock edge where start is high and busy is low.
//   Result channel: result_o is shown for one cycle with result_valid_o high,
//   in the cycle after the request finishes; the receiver cannot stall it.
//   Sequence: a report at or above the threshold gives its result without
//   leaving idle. A low-stack report walks the tracked entries through the
//   memory read port, one entry a cycle, then updates the matched or a new
//   entry; a full table with no match answers from the search. End of cycle
//   walks the tracked entries the same way, keeping the seen ones in order.
//   No request is taken while busy is high; a new request can be taken in
//   the cycle its predecessor's result is shown. Configuration: the user
//   makes APB writes at 0x0 (critical threshold) and 0x4 (escalation limit)
//   with the block idle, unenforced by the block; pready is always high.
//   Reset: the table is empty (entry count zero), threshold 256, limit 5.
//   No clearing pass is run; the memory is never read past the entry count.
// ----------------------------------------------------------------------------
`default_nettype none

module stack_watch_escalation_table #(
  parameter int WATCH_ENTRIES = swet_pkg::WATCH_ENTRIES_DEF
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        start,
  output logic                             busy,
  input  wire swet_pkg::in_t               req_i,
  output logic                             result_valid_o,
  output swet_pkg::out_t                   result_o,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [swet_pkg::APB_AW-1:0] paddr,
  input  wire logic [swet_pkg::APB_DW-1:0] pwdata,
  output logic      [swet_pkg::APB_DW-1:0] prdata,
  output logic                             pready
);

  localparam int IW = (WATCH_ENTRIES > 1) ? $clog2(WATCH_ENTRIES) : 1;
  localparam int CW = $clog2(WATCH_ENTRIES + 1);

  swet_pkg::cfg_t   cfg;
  logic             mem_we;
  logic [IW-1:0]    mem_waddr;
  swet_pkg::entry_t mem_wdata;
  logic             mem_re;
  logic [IW-1:0]    mem_raddr;
  swet_pkg::entry_t mem_rdata;

  swet_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  swet_mem #(
    .DEPTH (WATCH_ENTRIES),
    .AW    (IW)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  swet_ctrl #(
    .WATCH_ENTRIES (WATCH_ENTRIES),
    .IW            (IW),
    .CW            (CW)
  ) u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .req_i          (req_i),
    .cfg_i          (cfg),
    .result_valid_o (result_valid_o),
    .result_o       (result_o),
    .mem_we_o       (mem_we),
    .mem_waddr_o    (mem_waddr),
    .mem_wdata_o    (mem_wdata),
    .mem_re_o       (mem_re),
    .mem_raddr_o    (mem_raddr),
    .mem_rdata_i    (mem_rdata)
  );

endmodule

`default_nettype wire

// ===== rtl/swet_mem.sv =====
// ----------------------------------------------------------------------------
// swet_mem
// Watch table storage, one write and one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module swet_mem #(
  parameter int DEPTH = swet_pkg::WATCH_ENTRIES_DEF,
  parameter int AW    = 3
) (
  input  wire logic            clk_i,
  input  wire logic            we_i,
  input  wire logic [AW-1:0]   waddr_i,
  input  wire swet_pkg::entry_t wdata_i,
  input  wire logic            re_i,
  input  wire logic [AW-1:0]   raddr_i,
  output swet_pkg::entry_t     rdata_o
);

  swet_pkg::entry_t mem_q [DEPTH];
  swet_pkg::entry_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ===== rtl/swet_cfg.sv =====
// ----------------------------------------------------------------------------
// swet_cfg
// APB register file: critical threshold and escalation limit.
// ----------------------------------------------------------------------------
`default_nettype none

module swet_cfg (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [swet_pkg::APB_AW-1:0] paddr,
  input  wire logic [swet_pkg::APB_DW-1:0] pwdata,
  output logic      [swet_pkg::APB_DW-1:0] prdata,
  output logic                             pready,
  output swet_pkg::cfg_t                   cfg_o
);

  logic [15:0] threshold_q;
  logic [3:0]  limit_q;
  logic        wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      threshold_q <= swet_pkg::THRESHOLD_RST;
      limit_q     <= swet_pkg::LIMIT_RST;
    end else if (wr_en) begin
      case (paddr[2])
        swet_pkg::REG_THRESHOLD: threshold_q <= pwdata[15:0];
        swet_pkg::REG_LIMIT:     limit_q     <= pwdata[3:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      swet_pkg::REG_THRESHOLD: prdata = {16'd0, threshold_q};
      swet_pkg::REG_LIMIT:     prdata = {28'd0, limit_q};
      default:                 prdata = '0;
    endcase
  end

  assign cfg_o.threshold = threshold_q;
  assign cfg_o.limit     = limit_q;

endmodule

`default_nettype wire

// ===== rtl/swet_ctrl.sv =====
// ----------------------------------------------------------------------------
// swet_ctrl
// Sequencer: table search, entry update and end-of-cycle compaction.
// ----------------------------------------------------------------------------
`default_nettype none

module swet_ctrl #(
  parameter int WATCH_ENTRIES = swet_pkg::WATCH_ENTRIES_DEF,
  parameter int IW            = 3,
  parameter int CW            = 4
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          start,
  output logic               busy,
  input  wire swet_pkg::in_t req_i,
  input  wire swet_pkg::cfg_t cfg_i,
  output logic               result_valid_o,
  output swet_pkg::out_t     result_o,
  output logic               mem_we_o,
  output logic [IW-1:0]      mem_waddr_o,
  output swet_pkg::entry_t   mem_wdata_o,
  output logic               mem_re_o,
  output logic [IW-1:0]      mem_raddr_o,
  input  wire swet_pkg::entry_t mem_rdata_i
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SRCH = 2'd1;
  localparam logic [1:0] ST_UPD  = 2'd2;
  localparam logic [1:0] ST_CMPT = 2'd3;

  localparam logic [CW-1:0] FULL_CNT = CW'(WATCH_ENTRIES);

  logic [1:0]       state_q, state_d;
  logic [15:0]      id_q, id_d;
  logic [CW-1:0]    ptr_q, ptr_d;
  logic [CW-1:0]    count_q, count_d;
  logic [CW-1:0]    kept_q, kept_d;
  logic [IW-1:0]    chk_idx_q, chk_idx_d;
  logic             chk_vld_q, chk_vld_d;
  logic [IW-1:0]    idx_q, idx_d;
  swet_pkg::entry_t ent_q, ent_d;
  swet_pkg::out_t   res_q, res_d;
  logic             res_vld_q, res_vld_d;

  always_comb begin
    logic [3:0]    sat;
    logic [CW+3:0] cnt_ext;
    logic          match;

    state_d   = state_q;
    id_d      = id_q;
    ptr_d     = ptr_q;
    count_d   = count_q;
    kept_d    = kept_q;
    chk_idx_d = chk_idx_q;
    chk_vld_d = chk_vld_q;
    idx_d     = idx_q;
    ent_d     = ent_q;
    res_d     = res_q;
    res_vld_d = 1'b0;

    mem_we_o    = 1'b0;
    mem_waddr_o = idx_q;
    mem_wdata_o = ent_q;
    mem_re_o    = 1'b0;
    mem_raddr_o = ptr_q[IW-1:0];

    match = chk_vld_q && (mem_rdata_i.task_id == id_q);
    sat   = (ent_q.streak == swet_pkg::STREAK_MAX) ? ent_q.streak : ent_q.streak + 4'd1;

    case (state_q)
      ST_IDLE: begin
        if (start) begin
          ptr_d     = '0;
          chk_vld_d = 1'b0;
          kept_d    = '0;
          if (req_i.command == swet_pkg::CMD_END) begin
            state_d = ST_CMPT;
          end else if (req_i.stack_free < cfg_i.threshold) begin
            id_d    = req_i.task_id;
            state_d = ST_SRCH;
          end else begin
            res_d     = '0;
            res_vld_d = 1'b1;
          end
        end
      end
      ST_SRCH: begin
        if (match) begin
          idx_d     = chk_idx_q;
          ent_d     = mem_rdata_i;
          chk_vld_d = 1'b0;
          state_d   = ST_UPD;
        end else if (ptr_q < count_q) begin
          mem_re_o  = 1'b1;
          chk_idx_d = ptr_q[IW-1:0];
          chk_vld_d = 1'b1;
          ptr_d     = ptr_q + CW'(1);
        end else if (count_q >= FULL_CNT) begin
          res_d            = '0;
          res_d.low_stack  = 1'b1;
          res_d.table_full = 1'b1;
          res_vld_d        = 1'b1;
          chk_vld_d        = 1'b0;
          state_d          = ST_IDLE;
        end else begin
          idx_d         = count_q[IW-1:0];
          ent_d.task_id = id_q;
          ent_d.streak  = '0;
          ent_d.alerted = 1'b0;
          ent_d.seen    = 1'b0;
          count_d       = count_q + CW'(1);
          chk_vld_d     = 1'b0;
          state_d       = ST_UPD;
        end
      end
      ST_UPD: begin
        res_d                 = '0;
        res_d.low_stack       = 1'b1;
        res_d.alert           = !ent_q.alerted;
        res_d.restart_request = (sat >= cfg_i.limit);
        res_d.streak          = sat;
        res_vld_d             = 1'b1;
        if (sat >= cfg_i.limit) begin
          count_d = '0;
        end else begin
          mem_we_o            = 1'b1;
          mem_waddr_o         = idx_q;
          mem_wdata_o.task_id = ent_q.task_id;
          mem_wdata_o.streak  = sat;
          mem_wdata_o.alerted = 1'b1;
          mem_wdata_o.seen    = 1'b1;
        end
        state_d = ST_IDLE;
      end
      ST_CMPT: begin
        if (chk_vld_q && mem_rdata_i.seen) begin
          mem_we_o         = 1'b1;
          mem_waddr_o      = kept_q[IW-1:0];
          mem_wdata_o      = mem_rdata_i;
          mem_wdata_o.seen = 1'b0;
          kept_d           = kept_q + CW'(1);
        end
        if (ptr_q < count_q) begin
          mem_re_o  = 1'b1;
          chk_vld_d = 1'b1;
          ptr_d     = ptr_q + CW'(1);
        end else begin
          count_d   = kept_d;
          chk_vld_d = 1'b0;
          res_d     = '0;
          res_vld_d = 1'b1;
          state_d   = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    cnt_ext = {4'd0, count_d};
    if (res_vld_d) begin
      res_d.entries_in_use = cnt_ext[3:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      count_q   <= '0;
      chk_vld_q <= 1'b0;
      res_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      count_q   <= count_d;
      chk_vld_q <= chk_vld_d;
      res_vld_q <= res_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    id_q      <= id_d;
    ptr_q     <= ptr_d;
    kept_q    <= kept_d;
    chk_idx_q <= chk_idx_d;
    idx_q     <= idx_d;
    ent_q     <= ent_d;
    res_q     <= res_d;
  end

  assign busy           = (state_q != ST_IDLE);
  assign result_valid_o = res_vld_q;
  assign result_o       = res_q;

endmodule

`default_nettype wire

// ===== rtl/swet_chk.sv =====
// ----------------------------------------------------------------------------
// swet_chk
// Port-level checks of the escalation table, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "stack_watch_escalation_table_defines.svh"

module swet_chk (
  input wire logic           clk_i,
  input wire logic           rst_ni,
  input wire logic           start,
  input wire logic           busy,
  input wire logic           result_valid_o,
  input wire swet_pkg::out_t result_o
);

  `SWET_ASSERT_NXT(a_req_progress, clk_i, rst_ni,
                   start && !busy,
                   busy || result_valid_o,
                   "request neither in progress nor answered")
  `SWET_ASSERT_IMP(a_restart_clears, clk_i, rst_ni,
                   result_valid_o && result_o.restart_request,
                   result_o.entries_in_use == 4'd0 && result_o.low_stack &&
                   result_o.streak != 4'd0,
                   "restart without empty table")
  `SWET_ASSERT_IMP(a_full_drops, clk_i, rst_ni,
                   result_valid_o && result_o.table_full,
                   result_o.low_stack && !result_o.alert && !result_o.restart_request &&
                   result_o.streak == 4'd0,
                   "dropped request shows entry update")
  `SWET_ASSERT_IMP(a_quiet_report, clk_i, rst_ni,
                   result_valid_o && !result_o.low_stack,
                   !result_o.alert && !result_o.restart_request && !result_o.table_full &&
                   result_o.streak == 4'd0,
                   "flags on a request that was not low")

endmodule

bind stack_watch_escalation_table swet_chk u_swet_chk (.*);

`default_nettype wire

// ===== test/swet_outcome_checker.sv =====
// ----------------------------------------------------------------------------
// swet_outcome_checker
// Watches the request, result and APB channels of the stack watch escalation
// table, keeps its own copy of the watch table and registers, and compares
// every result field by field against the outcome predicted for its request.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module swet_outcome_checker #(
  parameter int WATCH_ENTRIES = swet_pkg::WATCH_ENTRIES_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic                         busy_i,
  input  swet_pkg::in_t                req_i,
  input  logic                         result_valid_i,
  input  swet_pkg::out_t               result_i,
  input  logic                         psel_i,
  input  logic                         penable_i,
  input  logic                         pwrite_i,
  input  logic [swet_pkg::APB_AW-1:0]  paddr_i,
  input  logic [swet_pkg::APB_DW-1:0]  pwdata_i,
  input  logic                         pready_i,
  output int                           mismatch_count_o,
  output int                           pending_count_o
);

  import swet_pkg::*;

  logic [15:0]     threshold;
  logic [3:0]      limit;
  entry_t          watch [WATCH_ENTRIES];
  int              watch_count;
  out_t            outcome_q [$];
  int              mismatches;
  int              pending;

  assign mismatch_count_o = mismatches;
  assign pending_count_o  = pending;

  task automatic clear_watch();
    for (int i = 0; i < WATCH_ENTRIES; i++) watch[i] = '0;
    watch_count = 0;
  endtask

  task automatic track_report(input in_t req, output out_t res);
    int kept;
    int idx;
    res = '0;
    if (req.command == CMD_END) begin
      kept = 0;
      for (int i = 0; i < watch_count; i++) begin
        if (watch[i].seen) begin
          watch[kept].task_id = watch[i].task_id;
          watch[kept].streak  = watch[i].streak;
          watch[kept].alerted = watch[i].alerted;
          kept++;
        end
      end
      for (int i = 0; i < WATCH_ENTRIES; i++) begin
        watch[i].seen = 1'b0;
        if (i >= kept) begin
          watch[i].streak  = '0;
          watch[i].alerted = 1'b0;
        end
      end
      watch_count = kept;
    end else if (req.stack_free < threshold) begin
      res.low_stack = 1'b1;
      idx = -1;
      for (int i = 0; i < watch_count; i++) begin
        if (idx < 0 && watch[i].task_id == req.task_id) idx = i;
      end
      if (idx < 0) begin
        if (watch_count >= WATCH_ENTRIES) begin
          res.table_full = 1'b1;
        end else begin
          idx = watch_count;
          watch_count++;
          watch[idx].task_id = req.task_id;
          watch[idx].streak  = '0;
          watch[idx].alerted = 1'b0;
        end
      end
      if (idx >= 0) begin
        watch[idx].seen = 1'b1;
        if (watch[idx].streak < STREAK_MAX) watch[idx].streak = watch[idx].streak + 4'd1;
        res.streak = watch[idx].streak;
        if (!watch[idx].alerted) begin
          watch[idx].alerted = 1'b1;
          res.alert = 1'b1;
        end
        if (res.streak >= limit) begin
          res.restart_request = 1'b1;
          clear_watch();
        end
      end
    end
    res.entries_in_use = watch_count[3:0];
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    out_t want;
    out_t got;
    if (!rst_ni) begin
      threshold = THRESHOLD_RST;
      limit     = LIMIT_RST;
      clear_watch();
      outcome_q.delete();
      mismatches = 0;
      pending    = 0;
    end else begin
      if (psel_i && penable_i && pwrite_i && pready_i) begin
        if (paddr_i[APB_AW-1:2] == REG_THRESHOLD) threshold = pwdata_i[15:0];
        else if (paddr_i[APB_AW-1:2] == REG_LIMIT) limit = pwdata_i[3:0];
      end
      if (result_valid_i) begin
        got = result_i;
        if (outcome_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("%0t unexpected result %h", $time, got);
        end else begin
          want = outcome_q.pop_front();
          if (got.low_stack !== want.low_stack || got.alert !== want.alert ||
              got.restart_request !== want.restart_request ||
              got.table_full !== want.table_full || got.streak !== want.streak ||
              got.entries_in_use !== want.entries_in_use) begin
            mismatches++;
            if (mismatches <= 10)
              $display({"%0t result mismatch: expected low=%0d alert=%0d restart=%0d ",
                        "full=%0d streak=%0d entries=%0d, got low=%0d alert=%0d ",
                        "restart=%0d full=%0d streak=%0d entries=%0d"}, $time,
                       want.low_stack, want.alert, want.restart_request, want.table_full,
                       want.streak, want.entries_in_use, got.low_stack, got.alert,
                       got.restart_request, got.table_full, got.streak, got.entries_in_use);
          end
        end
      end
      if (start_i && !busy_i) begin
        track_report(req_i, want);
        outcome_q.push_back(want);
      end
      pending = outcome_q.size();
    end
  end

endmodule

// ===== test/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Stimulus for the stack watch escalation table: a directed pass over the
// field extremes and table corner cases, then phases of monitoring cycles
// over small task pools under several register settings, with bursty
// requests. The checker beside the block predicts and compares results.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;

  import swet_pkg::*;

  localparam int                PHASE_ITEMS = 250;
  localparam int                SETTLE      = WATCH_ENTRIES_DEF + 4;
  localparam logic [APB_AW-1:0] ADDR_THRESHOLD = {REG_THRESHOLD, 2'b00};
  localparam logic [APB_AW-1:0] ADDR_LIMIT     = {REG_LIMIT, 2'b00};

  logic              clk_i   = 1'b0;
  logic              rst_ni  = 1'b0;
  logic              start   = 1'b0;
  logic              busy;
  in_t               req     = '0;
  logic              result_valid;
  out_t              result;
  logic              psel    = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite  = 1'b0;
  logic [APB_AW-1:0] paddr   = '0;
  logic [APB_DW-1:0] pwdata  = '0;
  logic [APB_DW-1:0] prdata;
  logic              pready;
  int                mismatch_count;
  int                pending_count;

  logic [15:0]       cur_threshold;
  int                burst_left;
  bit                gap_free;

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  stack_watch_escalation_table #(.WATCH_ENTRIES(WATCH_ENTRIES_DEF)) u_dut (
    .clk_i, .rst_ni, .start, .busy, .req_i(req), .result_valid_o(result_valid),
    .result_o(result), .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  swet_outcome_checker #(.WATCH_ENTRIES(WATCH_ENTRIES_DEF)) u_checker (
    .clk_i, .rst_ni, .start_i(start), .busy_i(busy), .req_i(req),
    .result_valid_i(result_valid), .result_i(result), .psel_i(psel),
    .penable_i(penable), .pwrite_i(pwrite), .paddr_i(paddr), .pwdata_i(pwdata),
    .pready_i(pready), .mismatch_count_o(mismatch_count),
    .pending_count_o(pending_count)
  );

  task automatic take_break(input int cycles);
    start <= 1'b0;
    repeat (cycles) @(negedge clk_i);
  endtask

  task automatic issue(input logic cmd, input logic [15:0] id, input logic [15:0] free_b);
    in_t item;
    item.command    = cmd;
    item.task_id    = id;
    item.stack_free = free_b;
    start <= 1'b1;
    req   <= item;
    while (busy) @(negedge clk_i);
    @(negedge clk_i);
    if (burst_left == 0) begin
      if (!gap_free) take_break($urandom_range(1, 14));
      burst_left = $urandom_range(1, 16);
    end
    burst_left--;
  endtask

  task automatic settle();
    take_break(1);
    while (pending_count != 0) @(negedge clk_i);
    repeat (SETTLE) @(negedge clk_i);
  endtask

  task automatic apb_write(input logic [APB_AW-1:0] addr, input logic [APB_DW-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(negedge clk_i);
    penable <= 1'b1;
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic configure(input logic [15:0] thr, input logic [3:0] lim);
    apb_write(ADDR_THRESHOLD, {16'h0, thr});
    apb_write(ADDR_LIMIT, {28'h0, lim});
    cur_threshold = thr;
  endtask

  task automatic run_phase();
    logic [15:0] pool [12];
    int          pool_size;
    int          sent;
    int          reports;
    logic [15:0] free_b;
    pool_size = $urandom_range(1, 12);
    for (int i = 0; i < 12; i++) pool[i] = 16'($urandom_range(65535, 0));
    gap_free = ($urandom_range(0, 3) == 0);
    sent = 0;
    while (sent < PHASE_ITEMS) begin
      if ($urandom_range(0, 99) < 12) begin
        issue(1'($urandom_range(0, 1)), 16'($urandom_range(65535, 0)),
              16'($urandom_range(65535, 0)));
        sent++;
      end else begin
        reports = $urandom_range(0, 10);
        for (int r = 0; r < reports; r++) begin
          if (cur_threshold != 0 && $urandom_range(0, 99) < 80)
            free_b = 16'($urandom_range(int'(cur_threshold) - 1, 0));
          else
            free_b = 16'($urandom_range(65535, 0));
          issue(CMD_REPORT, pool[$urandom_range(0, pool_size - 1)], free_b);
        end
        issue(CMD_END, 16'($urandom_range(65535, 0)), 16'($urandom_range(65535, 0)));
        sent += reports + 1;
      end
    end
  endtask

  initial begin
    logic [15:0] thr_list [8] = '{16'hFFFF, 16'd0, 16'd1, 16'd256, 16'd0, 16'd64,
                                  16'd4096, 16'd0};
    logic [3:0]  lim_list [8] = '{4'd15, 4'd1, 4'd0, 4'd5, 4'd0, 4'd3, 4'd2, 4'd0};
    cur_threshold = THRESHOLD_RST;
    burst_left    = 0;
    gap_free      = 1'b0;
    repeat (4) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    issue(CMD_REPORT, 16'h0000, 16'h0000);
    issue(CMD_REPORT, 16'hFFFF, 16'hFFFF);
    issue(CMD_REPORT, 16'h0000, 16'd255);
    issue(CMD_REPORT, 16'hFFFF, 16'd256);
    for (int i = 1; i < 8; i++) issue(CMD_REPORT, i[15:0], 16'h0000);
    issue(CMD_REPORT, 16'hFFFF, 16'h0000);
    issue(CMD_END, 16'hFFFF, 16'hFFFF);
    issue(CMD_REPORT, 16'h0000, 16'h0000);
    issue(CMD_REPORT, 16'h0000, 16'h0000);
    issue(CMD_REPORT, 16'h0000, 16'h0000);
    issue(CMD_END, 16'h0000, 16'h0000);
    issue(CMD_REPORT, 16'h00AA, 16'h0000);
    issue(CMD_REPORT, 16'h0055, 16'h0000);
    issue(CMD_END, 16'h0000, 16'h0000);
    issue(CMD_REPORT, 16'h0055, 16'h0000);
    issue(CMD_END, 16'h0000, 16'h0000);
    settle();
    configure(THRESHOLD_RST, 4'd1);
    issue(CMD_REPORT, 16'h1234, 16'h0000);
    issue(CMD_END, 16'h0000, 16'h0000);

    for (int p = 0; p < 8; p++) begin
      settle();
      if (thr_list[p] == 16'd0 && p >= 4) thr_list[p] = 16'($urandom_range(65535, 1));
      if (p == 7) lim_list[p] = 4'($urandom_range(15, 0));
      configure(thr_list[p], lim_list[p]);
      run_phase();
    end

    settle();
    if (mismatch_count == 0 && pending_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin
    #5000000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
